// ===== hdl/sev_pkg.sv =====
// Shared types, constants and helpers for the skyline envelope update block.
// Used by the segment cell, the merge unit and the top level.
package sev_pkg;

    localparam int COORD_BITS       = 32;
    localparam int CW               = COORD_BITS - 1;
    localparam int LW               = 32;
    localparam int DEF_MAX_SEGMENTS = 64;

    localparam logic [CW-1:0] COORD_MAX = {CW{1'b1}};
    localparam logic [LW-1:0] LEVEL_HI  = {1'b0, {(LW-1){1'b1}}};
    localparam logic [LW-1:0] LEVEL_LO  = {1'b1, {(LW-1){1'b0}}};

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    typedef struct packed {
        logic [LW-1:0] level;
        logic [CW-1:0] width;
    } seg_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] end_c;
        logic [CW-1:0] w;
        logic [LW-1:0] y;
    } span_t;

    typedef struct packed {
        logic init;
        logic step;
        logic merge_en;
        logic head_real;
        logic at_tail;
        logic keep_min;
    } sweep_ctl_t;

    typedef struct packed {
        logic live;
        seg_t seg;
    } emit_t;

    function automatic logic is_better(input logic keep_min, input logic [LW-1:0] cur,
                                       input logic [LW-1:0] lvl);
        is_better = keep_min ? ($signed(lvl) < $signed(cur)) : ($signed(lvl) > $signed(cur));
    endfunction

endpackage

// ===== hdl/skyline_envelope_update.sv =====
// Top level of the skyline envelope update block: request handshake, span clipping,
// sweep control over the segment cell chain, result register. Uses sev_pkg,
// sev_cell and sev_merge.
//
// Every request (add, clear, read) runs through the same steps from one accepted
// transaction to the next: accept, clip the span, rotate the whole cell chain once
// through the merge unit at its head, and load the result register. The chain
// rotates one segment per cycle. The next transaction is accepted while the result
// still waits to be taken; a sweep that ends while the result register is full
// holds until it drains.
module skyline_envelope_update
    import sev_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1),
    localparam int IW = $clog2(MAX_SEGMENTS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 keep_minimum,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic signed [LW-1:0] span_left,
    input  logic signed [LW-1:0] span_level,
    input  logic [CW-1:0]        span_width,
    input  logic [IW-1:0]        read_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [LW-1:0] extreme_level,
    output logic [CNTW-1:0]      segment_count,
    output logic                 overflow_flag,
    output logic [CW-1:0]        read_start,
    output logic signed [LW-1:0] read_level,
    output logic [CW-1:0]        read_width
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CLIP   = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_SEGMENTS);

    state_t          state_reg;
    state_t          state_next;
    logic [CNTW-1:0] t_reg;
    logic [CNTW-1:0] used_reg;
    logic            ovf_reg;
    logic            keep_min_reg;
    logic            out_valid_reg;

    req_t            req_reg;
    logic [LW-1:0]   span_x_reg;
    logic [LW:0]     end_raw_reg;
    logic [LW-1:0]   y_reg;
    logic [IW-1:0]   rd_index_reg;
    span_t           span_reg;
    logic [LW-1:0]   ext_reg;
    logic [CW-1:0]   run_start_reg;
    logic [CW-1:0]   rd_start_reg;
    logic [LW-1:0]   rd_level_reg;
    logic [CW-1:0]   rd_width_reg;
    logic [LW-1:0]   ext_out_reg;
    logic [CNTW-1:0] cnt_out_reg;
    logic            ovf_out_reg;
    logic [CW-1:0]   rs_out_reg;
    logic [LW-1:0]   rl_out_reg;
    logic [CW-1:0]   rw_out_reg;

    logic            in_fire;
    logic            load;
    logic            shift;
    logic            sweeping;
    logic [CNTW-1:0] used_start;
    logic [CW-1:0]   clip_x;
    logic [CW-1:0]   clip_end;
    logic            span_ok;
    logic [LW-1:0]   empty_level;
    sweep_ctl_t      ctl;
    emit_t           emit;
    logic [CNTW-1:0] merge_count;
    logic            ovf_set;
    seg_t            chain [MAX_SEGMENTS];

    assign in_fire     = in_valid && in_ready;
    assign in_ready    = state_reg == ST_IDLE;
    assign cfg_ready   = 1'b1;
    assign sweeping    = state_reg == ST_SWEEP;
    assign shift       = sweeping && (t_reg != MAXC);
    assign load        = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign used_start  = (req_reg == REQ_CLEAR) ? '0 : used_reg;
    assign empty_level = keep_min_reg ? LEVEL_HI : LEVEL_LO;

    // clip at zero on the left and at the coordinate limit on the right
    assign clip_x   = span_x_reg[LW-1] ? '0 : span_x_reg[CW-1:0];
    assign clip_end = (!end_raw_reg[LW] && end_raw_reg[LW-1]) ? COORD_MAX : end_raw_reg[CW-1:0];
    assign span_ok  = !end_raw_reg[LW] && (clip_end > clip_x);

    always_comb
    begin
        ctl.init      = state_reg == ST_CLIP;
        ctl.step      = sweeping;
        ctl.merge_en  = (req_reg == REQ_ADD) && span_ok;
        ctl.head_real = t_reg < used_start;
        ctl.at_tail   = t_reg == used_start;
        ctl.keep_min  = keep_min_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CLIP;
                end
            end
            ST_CLIP:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (t_reg == MAXC)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            if (g == MAX_SEGMENTS - 1)
            begin : g_last
                sev_cell u_cell (
                    .clk   (clk),
                    .shift (shift),
                    .din   (emit.seg),
                    .dout  (chain[g])
                );
            end
            else
            begin : g_mid
                sev_cell u_cell (
                    .clk   (clk),
                    .shift (shift),
                    .din   (chain[g+1]),
                    .dout  (chain[g])
                );
            end
        end
    endgenerate

    sev_merge #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .used_start (used_start),
        .span       (span_reg),
        .head       (chain[0]),
        .emit       (emit),
        .count      (merge_count),
        .ovf_set    (ovf_set)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            t_reg         <= '0;
            used_reg      <= '0;
            ovf_reg       <= 1'b0;
            keep_min_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLIP)
            begin
                t_reg <= '0;
            end
            else if (shift)
            begin
                t_reg <= t_reg + CNTW'(1);
            end
            if (cfg_valid)
            begin
                keep_min_reg <= keep_minimum;
            end
            if (ovf_set)
            begin
                ovf_reg <= 1'b1;
            end
            if (load)
            begin
                used_reg      <= merge_count;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg      <= req_t'(req_type);
            span_x_reg   <= span_left;
            end_raw_reg  <= {span_left[LW-1], span_left} + {2'b00, span_width};
            y_reg        <= span_level;
            rd_index_reg <= read_index;
        end
        if (state_reg == ST_CLIP)
        begin
            span_reg      <= '{x: clip_x, end_c: clip_end, w: clip_end - clip_x, y: y_reg};
            ext_reg       <= empty_level;
            run_start_reg <= '0;
            rd_start_reg  <= '0;
            rd_level_reg  <= '0;
            rd_width_reg  <= '0;
        end
        else if (shift && emit.live)
        begin
            // track the table as it is written back into the chain
            if (is_better(keep_min_reg, ext_reg, emit.seg.level))
            begin
                ext_reg <= emit.seg.level;
            end
            run_start_reg <= run_start_reg + emit.seg.width;
            if ((req_reg == REQ_READ) && (t_reg == CNTW'(rd_index_reg)))
            begin
                rd_start_reg <= run_start_reg;
                rd_level_reg <= emit.seg.level;
                rd_width_reg <= emit.seg.width;
            end
        end
        if (load)
        begin
            ext_out_reg <= ext_reg;
            cnt_out_reg <= merge_count;
            ovf_out_reg <= ovf_reg;
            rs_out_reg  <= rd_start_reg;
            rl_out_reg  <= rd_level_reg;
            rw_out_reg  <= rd_width_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign extreme_level = ext_out_reg;
    assign segment_count = cnt_out_reg;
    assign overflow_flag = ovf_out_reg;
    assign read_start    = rs_out_reg;
    assign read_level    = rl_out_reg;
    assign read_width    = rw_out_reg;

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag dropped");

    a_accept_clip: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_CLIP))
        else $error("accepted transaction did not start clipping");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (sweeping && (t_reg == MAXC)) |=> (state_reg == ST_FINISH))
        else $error("sweep did not end after a full rotation");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        merge_count <= MAXC)
        else $error("segment count past table size");

    a_no_tail_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (sweeping && (t_reg == MAXC)) |-> !emit.live)
        else $error("segment left over after rotation");

endmodule

// ===== hdl/sev_cell.sv =====
// One segment cell of the rotating segment chain: holds a level and a width.
// Depends on sev_pkg for the segment type.
module sev_cell
    import sev_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  seg_t din,
    output seg_t dout
);

    seg_t seg_reg;

    // advance the chain by one place
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            seg_reg <= din;
        end
    end

    assign dout = seg_reg;

endmodule

// ===== hdl/sev_merge.sv =====
// Merge unit at the head of the segment chain: rewrites one segment per step,
// queues up to two split pieces and appends tail segments. Depends on sev_pkg.
module sev_merge
    import sev_pkg::*;
#(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sweep_ctl_t       ctl,
    input  logic [CNTW-1:0]  used_start,
    input  span_t            span,
    input  seg_t             head,
    output emit_t            emit,
    output logic [CNTW-1:0]  count,
    output logic             ovf_set
);

    localparam logic [CNTW-1:0] ROOM1_LIM = CNTW'(MAX_SEGMENTS);
    localparam logic [CNTW-1:0] ROOM2_LIM = CNTW'(MAX_SEGMENTS - 1);

    logic [CW-1:0]   cx_reg;
    logic [CW-1:0]   cx_next;
    logic            active_reg;
    logic            active_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    seg_t            pend0_reg;
    seg_t            pend1_reg;
    logic [1:0]      pend_n_reg;
    logic [1:0]      pend_n_next;

    seg_t            p0, p1, p2;
    logic [1:0]      pc;
    seg_t            l0, l1, l2;
    logic [2:0]      ln;
    logic            ovf;

    logic [CW-1:0]   seg_end;
    logic            better;
    logic            room1;
    logic            room2;
    logic [CW-1:0]   w1;
    logic [CW-1:0]   w2;
    logic [CW-1:0]   w3;
    logic [CW-1:0]   wl;
    logic            need1;
    logic            need3;
    logic            fill;

    assign seg_end = cx_reg + head.width;
    assign better  = is_better(ctl.keep_min, head.level, span.y);
    assign room1   = count_reg < ROOM1_LIM;
    assign room2   = count_reg < ROOM2_LIM;
    assign w1      = span.x - cx_reg;
    assign w2      = seg_end - span.x;
    assign w3      = seg_end - span.end_c;
    assign wl      = span.end_c - cx_reg;
    assign need1   = w1 != '0;
    assign need3   = w3 != '0;
    assign fill    = span.x != cx_reg;

    always_comb
    begin
        p0          = head;
        p1          = head;
        p2          = head;
        pc          = 2'd0;
        ovf         = 1'b0;
        cx_next     = cx_reg;
        active_next = active_reg;
        count_next  = count_reg;
        if (ctl.head_real)
        begin
            cx_next = seg_end;
            pc      = 2'd1;
            if (!active_reg)
            begin
                p0 = head;
            end
            else if (span.end_c <= cx_reg)
            begin
                active_next = 1'b0;
            end
            else if (span.x > seg_end || !better)
            begin
                p0 = head;
            end
            else if (span.x >= cx_reg && span.end_c < seg_end)
            begin
                // span sits inside this segment: split into up to three pieces
                active_next = 1'b0;
                if ((need1 && need3) ? !room2 : ((need1 || need3) && !room1))
                begin
                    ovf = 1'b1;
                end
                else if (need1)
                begin
                    p0 = '{level: head.level, width: w1};
                    p1 = '{level: span.y, width: span.w};
                    p2 = '{level: head.level, width: w3};
                    pc = need3 ? 2'd3 : 2'd2;
                    count_next = count_reg + (need3 ? CNTW'(2) : CNTW'(1));
                end
                else
                begin
                    p0 = '{level: span.y, width: span.w};
                    p1 = '{level: head.level, width: w3};
                    pc = need3 ? 2'd2 : 2'd1;
                    count_next = count_reg + (need3 ? CNTW'(1) : CNTW'(0));
                end
            end
            else if (span.x <= cx_reg && span.end_c >= seg_end)
            begin
                p0 = '{level: span.y, width: head.width};
            end
            else if (span.x < cx_reg)
            begin
                // span ends inside this segment: new piece in front
                active_next = 1'b0;
                if (!room1)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    p0 = '{level: span.y, width: wl};
                    p1 = '{level: head.level, width: w3};
                    pc = 2'd2;
                    count_next = count_reg + CNTW'(1);
                end
            end
            else if (w2 != '0)
            begin
                // span starts inside this segment and runs past its end
                if (!room1)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    p0 = '{level: head.level, width: w1};
                    p1 = '{level: span.y, width: w2};
                    pc = 2'd2;
                    count_next = count_reg + CNTW'(1);
                end
            end
        end
        else if (active_reg && ctl.at_tail)
        begin
            active_next = 1'b0;
            if (span.x >= cx_reg)
            begin
                if (fill ? !room2 : !room1)
                begin
                    ovf = 1'b1;
                end
                else if (fill)
                begin
                    p0 = '{level: (ctl.keep_min ? LEVEL_HI : LEVEL_LO), width: w1};
                    p1 = '{level: span.y, width: span.w};
                    pc = 2'd2;
                    count_next = count_reg + CNTW'(2);
                end
                else
                begin
                    p0 = '{level: span.y, width: span.w};
                    pc = 2'd1;
                    count_next = count_reg + CNTW'(1);
                end
            end
            else if (span.end_c > cx_reg)
            begin
                if (!room1)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    p0 = '{level: span.y, width: wl};
                    pc = 2'd1;
                    count_next = count_reg + CNTW'(1);
                end
            end
        end
    end

    // queued pieces go out ahead of fresh ones
    always_comb
    begin
        case (pend_n_reg)
            2'd1:
            begin
                l0 = pend0_reg;
                l1 = p0;
                l2 = p1;
            end
            2'd2:
            begin
                l0 = pend0_reg;
                l1 = pend1_reg;
                l2 = p0;
            end
            default:
            begin
                l0 = p0;
                l1 = p1;
                l2 = p2;
            end
        endcase
        ln          = {1'b0, pend_n_reg} + {1'b0, pc};
        pend_n_next = (ln == 3'd0) ? 2'd0 : 2'(ln - 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            active_reg <= 1'b0;
            count_reg  <= '0;
            pend_n_reg <= 2'd0;
        end
        else if (ctl.init)
        begin
            cx_reg     <= '0;
            active_reg <= ctl.merge_en;
            count_reg  <= used_start;
            pend_n_reg <= 2'd0;
        end
        else if (ctl.step)
        begin
            cx_reg     <= cx_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            pend_n_reg <= pend_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            pend0_reg <= l1;
            pend1_reg <= l2;
        end
    end

    assign emit.live = ln != 3'd0;
    assign emit.seg  = l0;
    assign count     = count_reg;
    assign ovf_set   = ctl.step && ovf;

endmodule

// ===== sim/skyline_envelope_update_tb.sv =====
// Self-checking testbench for skyline_envelope_update: drives add, clear and read
// transactions, predicts every result with a scoreboard model of the envelope table.
// Depends on sev_pkg and the skyline_envelope_update RTL.
module skyline_envelope_update_tb;
    import sev_pkg::*;

    localparam int     SEGS      = 64;
    localparam longint SPAN_MAX  = 64'h7FFF_FFFF;
    localparam int     LIMIT     = 3000;
    localparam int     HOLD_LEN  = 600;
    localparam int     SETTLE    = 100;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] ext;
        logic [6:0]  cnt;
        logic        ovf;
        logic [30:0] rs;
        logic [31:0] rl;
        logic [30:0] rw;
    } status_t;

    class envelope_scoreboard;
        longint  seg_start[SEGS];
        longint  seg_level[SEGS];
        longint  seg_width[SEGS];
        int      used;
        bit      sticky;
        bit      keep_min;
        status_t pending[$];
        int      errors;
        int      checked;

        function new();
            used = 0;
            sticky = 0;
            keep_min = 1;
            errors = 0;
            checked = 0;
        endfunction

        function bit better(longint cur, longint lvl);
            return keep_min ? (lvl < cur) : (lvl > cur);
        endfunction

        function bit room(int need);
            return used + need <= SEGS;
        endfunction

        function void insert_at(int pos, longint s, longint l, longint w);
            for (int k = used; k > pos; k--)
            begin
                seg_start[k] = seg_start[k-1];
                seg_level[k] = seg_level[k-1];
                seg_width[k] = seg_width[k-1];
            end
            seg_start[pos] = s;
            seg_level[pos] = l;
            seg_width[pos] = w;
            used++;
        endfunction

        function void merge_span(longint x, longint y, longint w);
            int     i;
            bit     fin;
            longint cx, e, cy, wi, w1, w2, w3, acc;
            i = 0;
            fin = 0;
            if (x < 0)
            begin
                w += x;
                x = 0;
            end
            if (x + w > SPAN_MAX)
                w = SPAN_MAX - x;
            if (w <= 0)
                return;
            e = x + w;
            for (int k = 0; k < used; k++)
                if (seg_start[k] <= x)
                    i = k;
            cx = (used != 0) ? seg_start[i] : 0;
            while (!fin && i < used)
            begin
                cy = seg_level[i];
                wi = seg_width[i];
                if (e <= cx)
                    fin = 1;
                else if (x > cx + wi || !better(cy, y))
                    cx += wi;
                else if (x >= cx && e < cx + wi)
                begin
                    // span sits inside one segment: split into up to three
                    w1 = x - cx;
                    w3 = wi - w1 - w;
                    if (!room(int'(w1 > 0) + int'(w3 > 0)))
                        sticky = 1;
                    else
                    begin
                        if (w1 > 0)
                        begin
                            seg_width[i] = w1;
                            i++;
                            insert_at(i, x, y, w);
                        end
                        else
                        begin
                            seg_level[i] = y;
                            seg_width[i] = w;
                        end
                        if (w3 > 0)
                            insert_at(i + 1, e, cy, w3);
                    end
                    fin = 1;
                end
                else
                begin
                    if (x <= cx && e >= cx + wi)
                        seg_level[i] = y;
                    else if (x < cx)
                    begin
                        if (!room(1))
                            sticky = 1;
                        else
                        begin
                            w1 = e - cx;
                            seg_width[i] = wi - w1;
                            insert_at(i, cx, y, w1);
                        end
                        fin = 1;
                    end
                    else
                    begin
                        w1 = x - cx;
                        w2 = wi - w1;
                        if (w2 > 0)
                        begin
                            if (!room(1))
                                sticky = 1;
                            else
                            begin
                                seg_width[i] = w1;
                                cx += w1;
                                i++;
                                insert_at(i, cx, y, w2);
                            end
                        end
                    end
                    if (!fin)
                        cx += seg_width[i];
                end
                if (!fin)
                    i++;
            end
            if (!fin)
            begin
                if (x >= cx)
                begin
                    if (!room(int'(x > cx) + 1))
                        sticky = 1;
                    else
                    begin
                        // fill the gap past the end with an empty-level filler
                        if (x > cx)
                            insert_at(used, cx, keep_min ? 64'sh7FFF_FFFF : -64'sh8000_0000,
                                      x - cx);
                        insert_at(used, x, y, w);
                    end
                end
                else if (e > cx)
                begin
                    if (!room(1))
                        sticky = 1;
                    else
                        insert_at(used, cx, y, e - cx);
                end
            end
            acc = 0;
            for (int k = 0; k < used; k++)
            begin
                seg_start[k] = acc;
                acc += seg_width[k];
            end
        endfunction

        function void note_request(logic [1:0] req, logic [31:0] left, logic [31:0] lvl,
                                   logic [30:0] wid, logic [5:0] idx);
            status_t r;
            longint  ext;
            r.rs = '0;
            r.rl = '0;
            r.rw = '0;
            if (req == REQ_ADD)
                merge_span(longint'($signed(left)), longint'($signed(lvl)), longint'(wid));
            else if (req == REQ_CLEAR)
                used = 0;
            else if (req == REQ_READ && idx < used)
            begin
                r.rs = seg_start[idx][30:0];
                r.rl = seg_level[idx][31:0];
                r.rw = seg_width[idx][30:0];
            end
            ext = keep_min ? 64'sh7FFF_FFFF : -64'sh8000_0000;
            for (int k = 0; k < used; k++)
                if (keep_min ? (seg_level[k] < ext) : (seg_level[k] > ext))
                    ext = seg_level[k];
            r.ext = ext[31:0];
            r.cnt = used[6:0];
            r.ovf = sticky;
            pending.push_back(r);
        endfunction

        function void check_result(status_t got);
            status_t want;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: no prediction pending");
                return;
            end
            want = pending.pop_front();
            if (got.ext !== want.ext || got.cnt !== want.cnt || got.ovf !== want.ovf ||
                got.rs !== want.rs || got.rl !== want.rl || got.rw !== want.rw)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch #%0d exp ext=%h cnt=%0d ovf=%b rd=%h/%h/%h",
                             checked, want.ext, want.cnt, want.ovf, want.rs, want.rl, want.rw);
                    $display("    got ext=%h cnt=%0d ovf=%b rd=%h/%h/%h",
                             got.ext, got.cnt, got.ovf, got.rs, got.rl, got.rw);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               keep_minimum;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic signed [31:0] span_left;
    logic signed [31:0] span_level;
    logic [30:0]        span_width;
    logic [5:0]         read_index;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] extreme_level;
    logic [6:0]         segment_count;
    logic               overflow_flag;
    logic [30:0]        read_start;
    logic signed [31:0] read_level;
    logic [30:0]        read_width;

    envelope_scoreboard sb = new();

    int  accepted_n;
    int  idle_cnt;
    int  add_n, read_n, clear_n;
    bit  quiet;
    bit  hold_done;
    bit  ovf_seen;

    skyline_envelope_update uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .keep_minimum(keep_minimum),
        .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
        .span_left(span_left), .span_level(span_level), .span_width(span_width),
        .read_index(read_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .extreme_level(extreme_level), .segment_count(segment_count),
        .overflow_flag(overflow_flag), .read_start(read_start),
        .read_level(read_level), .read_width(read_width)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // transaction monitors
    always @(posedge clk)
    begin
        status_t got;
        if (cfg_valid && cfg_ready)
            sb.keep_min = keep_minimum;
        if (in_valid && in_ready)
        begin
            sb.note_request(req_type, span_left, span_level, span_width, read_index);
            accepted_n++;
        end
        if (out_valid && out_ready)
        begin
            got.ext = extreme_level;
            got.cnt = segment_count;
            got.ovf = overflow_flag;
            got.rs  = read_start;
            got.rl  = read_level;
            got.rw  = read_width;
            if (overflow_flag === 1'b1)
                ovf_seen = 1;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", LIMIT);
            $display("[skyline_envelope_update] ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to back up the input
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && accepted_n >= 400)
            begin
                hold_done = 1;
                hold = HOLD_LEN;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic send(logic [1:0] req, logic [31:0] left, logic [31:0] lvl,
                        logic [30:0] wid, logic [5:0] idx);
        while (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        span_left  <= left;
        span_level <= lvl;
        span_width <= wid;
        read_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        case (req)
            REQ_ADD:   add_n++;
            REQ_CLEAR: clear_n++;
            REQ_READ:  read_n++;
            default:   ;
        endcase
    endtask

    task automatic set_mode(bit m);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid    <= 1'b1;
        keep_minimum <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] left, lvl;
        logic [30:0] wid;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            send(REQ_CLEAR, $urandom, $urandom, 31'($urandom), 6'($urandom));
        else if (pick < 17)
            send(REQ_READ, '0, '0, '0,
                 ($urandom_range(0, 9) == 0) ? 6'($urandom) :
                 6'($urandom_range(0, (sb.used > 0) ? sb.used - 1 : 0)));
        else if (pick < 18)
            send(REQ_UNUSED, $urandom, $urandom, 31'($urandom), 6'($urandom));
        else
        begin
            // mostly small spans near the table so they overlap; some raw values
            left = 32'($urandom_range(0, 4200)) - 32'd200;
            lvl  = 32'($urandom_range(0, 200)) - 32'd100;
            wid  = 31'($urandom_range(0, 600));
            if ($urandom_range(0, 9) == 0) left = $urandom;
            if ($urandom_range(0, 9) == 0) lvl = $urandom;
            if ($urandom_range(0, 9) == 0) wid = 31'($urandom);
            send(REQ_ADD, left, lvl, wid, 6'($urandom));
        end
    endtask

    initial
    begin
        rst_n        = 0;
        cfg_valid    = 0;
        keep_minimum = 1;
        in_valid     = 0;
        req_type     = REQ_ADD;
        span_left    = 0;
        span_level   = 0;
        span_width   = 0;
        read_index   = 0;
        idle_cnt     = 0;
        accepted_n   = 0;
        quiet        = 0;
        hold_done    = 0;
        ovf_seen     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(1'b1);
        send(REQ_READ, '0, '0, '0, 6'd0);
        send(REQ_ADD, 32'd100, 32'd10, 31'd100, '0);             // gap filler then span
        send(REQ_ADD, 32'd120, 32'd5, 31'd20, '0);               // split in the middle
        send(REQ_ADD, 32'd120, 32'd20, 31'd20, '0);              // not better
        send(REQ_ADD, -32'sd50, 32'd0, 31'd80, '0);              // left clip
        send(REQ_ADD, -32'sd50, 32'd0, 31'd50, '0);              // clipped to empty
        send(REQ_ADD, 32'd300, 32'd7, 31'd0, '0);                // zero width
        send(REQ_ADD, 32'h7FFF_FF00, 32'd3, 31'h7FFF_FFFF, '0);  // right clip
        send(REQ_ADD, 32'd0, LEVEL_HI, 31'd1000, '0);            // empty level, not better
        send(REQ_ADD, 32'd10, LEVEL_LO, 31'd1, '0);
        send(REQ_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '0);
        for (int k = 0; k < 5; k++)
            send(REQ_READ, '0, '0, '0, 6'(k));
        send(REQ_READ, '0, '0, '0, 6'd63);                       // out of range
        send(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 6'd63);
        send(REQ_CLEAR, '0, '0, '0, '0);
        set_mode(1'b0);
        send(REQ_ADD, 32'd50, 32'd10, 31'd30, '0);
        send(REQ_ADD, 32'd60, 32'd20, 31'd5, '0);
        send(REQ_ADD, 32'd0, LEVEL_LO, 31'd500, '0);
        send(REQ_ADD, 32'd40, LEVEL_HI, 31'd30, '0);
        send(REQ_READ, '0, '0, '0, 6'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            set_mode(phase[0]);
            for (int n = 0; n < 250; n++)
            begin
                quiet = (phase == 2 && n >= 50 && n < 200);
                random_item();
            end
            quiet = 0;
            if (phase == 1)
                send(REQ_CLEAR, '0, '0, '0, '0);
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d adds, %0d reads, %0d clears in both modes, overflow %s",
                 add_n, read_n, clear_n, ovf_seen ? "reached" : "not reached");
        $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[skyline_envelope_update] OK");
        else
            $display("[skyline_envelope_update] ERROR");
        $finish;
    end

endmodule
